// ===== sv/sspt_pkg.sv =====
// ----------------------------------------------------------------------------
// sspt_pkg
// Shared types and constants of the stepper sweep peak tracker: command and
// result payloads, command classes, seek stages and the back-end sequencer.
// ----------------------------------------------------------------------------
package sspt_pkg;

  // Position range and intensity table size.
  localparam int POS_W     = 5;
  localparam int POSITIONS = 32;
  localparam int SAMPLE_W  = 8;

  // Configuration register layout.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_LAST_POSITION = 1'b0;
  localparam logic [POS_W-1:0] LAST_POSITION_RESET = 5'd17;

  // Operation codes carried in the command transaction.
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_LEFT  = 3'd1;
  localparam logic [2:0] OP_RIGHT = 3'd2;
  localparam logic [2:0] OP_ZERO  = 3'd3;
  localparam logic [2:0] OP_SEEK  = 3'd4;

  // One-hot coil drive patterns.
  localparam logic [2:0] COIL_A = 3'b010;
  localparam logic [2:0] COIL_B = 3'b001;
  localparam logic [2:0] COIL_C = 3'b100;

  typedef struct packed {
    logic [2:0]          operation;
    logic [SAMPLE_W-1:0] intensity;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0]       coil_phase;
    logic [POS_W-1:0] position;
    logic             moved;
    logic             seek_busy;
  } result_t;

  // Command classes after decoding by the front end.
  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_LEFT,
    CMD_RIGHT,
    CMD_ZERO,
    CMD_SEEK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [SAMPLE_W-1:0] intensity;
  } queue_entry_t;

  // Head of the command queue as seen by the back end.
  typedef struct packed {
    logic         valid;
    queue_entry_t entry;
  } queue_head_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NEAR,
    ST_FAR,
    ST_GOTO
  } seek_stage_t;

  typedef enum logic {
    BK_RUN,
    BK_SCAN
  } back_state_t;

endpackage

// ===== sv/sspt_front.sv =====
// ----------------------------------------------------------------------------
// sspt_front
// Accepts command transactions, decodes the operation into a command class
// and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module sspt_front
  import sspt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  cmd_item_t   cmd_data,
  output queue_head_t head,
  input  logic        pop
);

  queue_entry_t entries [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;
  logic         push;
  queue_entry_t decoded;

  // Unused operation codes behave as a plain tick.
  function automatic cmd_kind_t classify(input logic [2:0] op);
    cmd_kind_t k;
    unique case (op)
      OP_LEFT:  k = CMD_LEFT;
      OP_RIGHT: k = CMD_RIGHT;
      OP_ZERO:  k = CMD_ZERO;
      OP_SEEK:  k = CMD_SEEK;
      default:  k = CMD_TICK;
    endcase
    return k;
  endfunction

  assign cmd_stall = (count == 2'd2);
  assign push      = cmd_valid && !cmd_stall;

  always_comb begin
    decoded.kind      = classify(cmd_data.operation);
    decoded.intensity = cmd_data.intensity;
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= decoded;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.entry = entries[rptr];

endmodule

// ===== sv/sspt_back.sv =====
// ----------------------------------------------------------------------------
// sspt_back
// Executes queued commands: steps the motor, logs samples in the intensity
// table, runs the seek sequence and scans the table for the peak. Results
// leave through a registered output stage.
// ----------------------------------------------------------------------------
module sspt_back
  import sspt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [POS_W-1:0] last_position,
  input  queue_head_t      head,
  output logic             pop,
  output logic             res_valid,
  input  logic             res_stall,
  output result_t          res_data
);

  typedef struct packed {
    logic             moved;
    logic [POS_W-1:0] pos;
    logic [2:0]       coil;
  } step_t;

  logic [POS_W-1:0]    position;
  logic [2:0]          coil;
  seek_stage_t         stage;
  logic                sweep_dir;
  logic [POS_W-1:0]    target;
  logic [SAMPLE_W-1:0] table_mem [POSITIONS];

  back_state_t         bstate;
  back_state_t         bstate_next;
  logic [POS_W-1:0]    scan_idx;
  logic [POS_W-1:0]    best_idx;
  logic [SAMPLE_W-1:0] best_val;

  logic                slot_free;
  logic                take_item;
  logic                scan_active;

  logic                step_up;
  step_t               st;
  logic [POS_W-1:0]    position_next;
  logic [2:0]          coil_next;
  seek_stage_t         stage_next;
  logic                sweep_dir_next;
  logic                moved;
  logic                wr_en;
  logic                far_end;

  logic [SAMPLE_W-1:0] scan_val;
  logic                scan_better;
  logic [POS_W-1:0]    cand_idx;
  logic                scan_last;

  // One step attempt with limit check and coil advance.
  function automatic step_t step_calc(input logic up, input logic [POS_W-1:0] pos,
                                      input logic [2:0] cl,
                                      input logic [POS_W-1:0] last);
    step_t s;
    s.moved = 1'b0;
    s.pos   = pos;
    s.coil  = cl;
    if (up) begin
      if (pos < last) begin
        s.moved = 1'b1;
        s.pos   = pos + 1'b1;
        unique case (cl)
          COIL_A:  s.coil = COIL_C;
          COIL_B:  s.coil = COIL_A;
          COIL_C:  s.coil = COIL_B;
          default: s.coil = cl;
        endcase
      end
    end else begin
      if (pos != '0) begin
        s.moved = 1'b1;
        s.pos   = pos - 1'b1;
        unique case (cl)
          COIL_A:  s.coil = COIL_B;
          COIL_B:  s.coil = COIL_C;
          COIL_C:  s.coil = COIL_A;
          default: s.coil = cl;
        endcase
      end
    end
    return s;
  endfunction

  assign slot_free = !res_valid || !res_stall;

  // Sequencer next state.
  always_comb begin
    bstate_next = bstate;
    unique case (bstate)
      BK_RUN: begin
        if (take_item && far_end) begin
          bstate_next = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (scan_last) begin
          bstate_next = BK_RUN;
        end
      end
      default: bstate_next = BK_RUN;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    take_item   = 1'b0;
    scan_active = 1'b0;
    unique case (bstate)
      BK_RUN:  take_item = head.valid && slot_free;
      BK_SCAN: scan_active = 1'b1;
      default: take_item = 1'b0;
    endcase
  end

  assign pop = take_item;

  // Direction of the step attempt for the head command.
  always_comb begin
    unique case (stage)
      ST_NEAR, ST_FAR: step_up = sweep_dir;
      ST_GOTO:         step_up = (target > position);
      default:         step_up = (head.entry.kind == CMD_LEFT);
    endcase
    st = step_calc(step_up, position, coil, last_position);
  end

  // Command execution.
  always_comb begin
    position_next  = position;
    coil_next      = coil;
    stage_next     = stage;
    sweep_dir_next = sweep_dir;
    moved          = 1'b0;
    wr_en          = 1'b0;
    far_end        = 1'b0;
    unique case (stage)
      ST_NEAR: begin
        position_next = st.pos;
        coil_next     = st.coil;
        moved         = st.moved;
        wr_en         = 1'b1;
        if (!st.moved) begin
          sweep_dir_next = ~sweep_dir;
          stage_next     = ST_FAR;
        end
      end
      ST_FAR: begin
        position_next = st.pos;
        coil_next     = st.coil;
        moved         = st.moved;
        wr_en         = 1'b1;
        far_end       = !st.moved;
      end
      ST_GOTO: begin
        if (target != position) begin
          position_next = st.pos;
          coil_next     = st.coil;
          moved         = st.moved;
          wr_en         = 1'b1;
        end
        if (target == position_next) begin
          stage_next = ST_IDLE;
        end
      end
      default: begin
        unique case (head.entry.kind)
          CMD_LEFT, CMD_RIGHT: begin
            position_next = st.pos;
            coil_next     = st.coil;
            moved         = st.moved;
            wr_en         = 1'b1;
          end
          CMD_ZERO: position_next = '0;
          CMD_SEEK: begin
            // Sweep first toward the nearer limit.
            sweep_dir_next = ({position, 1'b0} < {1'b0, last_position}) ? 1'b0 : 1'b1;
            stage_next     = ST_NEAR;
          end
          default: position_next = position;
        endcase
      end
    endcase
  end

  // Peak scan over entries 0..last_position, one entry per cycle.
  assign scan_val    = table_mem[scan_idx];
  assign scan_better = (scan_val > best_val);
  assign cand_idx    = scan_better ? scan_idx : best_idx;
  assign scan_last   = scan_active && (scan_idx == last_position);

  // Intensity table.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < POSITIONS; i++) begin
        table_mem[i] <= '0;
      end
    end else if (take_item && wr_en) begin
      table_mem[position_next] <= head.entry.intensity;
    end
  end

  // Motor, seek and sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      bstate    <= BK_RUN;
      position  <= '0;
      coil      <= COIL_A;
      stage     <= ST_IDLE;
      sweep_dir <= 1'b0;
      target    <= '0;
      scan_idx  <= '0;
      best_idx  <= '0;
      best_val  <= '0;
    end else begin
      bstate <= bstate_next;
      if (take_item) begin
        position  <= position_next;
        coil      <= coil_next;
        stage     <= stage_next;
        sweep_dir <= sweep_dir_next;
        scan_idx  <= '0;
        best_idx  <= '0;
        best_val  <= '0;
      end else if (scan_active) begin
        if (scan_last) begin
          target <= cand_idx;
          stage  <= (cand_idx == position) ? ST_IDLE : ST_GOTO;
        end else begin
          scan_idx <= scan_idx + 1'b1;
          best_idx <= cand_idx;
          if (scan_better) begin
            best_val <= scan_val;
          end
        end
      end
    end
  end

  // Output stage valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((take_item && !far_end) || scan_last) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // Output stage payload.
  always_ff @(posedge clk) begin
    if (take_item && !far_end) begin
      res_data.coil_phase <= coil_next;
      res_data.position   <= position_next;
      res_data.moved      <= moved;
      res_data.seek_busy  <= (stage_next != ST_IDLE);
    end else if (scan_last) begin
      res_data.coil_phase <= coil;
      res_data.position   <= position;
      res_data.moved      <= 1'b0;
      res_data.seek_busy  <= (cand_idx != position);
    end
  end

endmodule

// ===== sv/stepper_sweep_peak_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// stepper_sweep_peak_tracker_unit
// Stepper positioner with per-position light logging and peak seeking.
// ----------------------------------------------------------------------------
// Each command transaction produces exactly one result transaction. A command
// enters a two-entry queue and is executed by the back end once it reaches
// the head and the output register is free, so ordinary commands sustain one
// per cycle while the output is not stalled. The command that ends the far
// sweep of a seek also scans intensity table entries 0 to last_position, one
// entry per cycle, and no other command is taken before its result appears.
// The register last_position sits at byte address 0 and should be written
// only while no command is in flight.
module stepper_sweep_peak_tracker_unit
  import sspt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  cmd_item_t          cmd_data,
  output logic               res_valid,
  input  logic               res_stall,
  output result_t            res_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [POS_W-1:0] last_position;
  queue_head_t      head;
  logic             pop;

  // Configuration register access.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_position <= LAST_POSITION_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_LAST_POSITION)) begin
      last_position <= pwdata[POS_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_LAST_POSITION) ?
                  {{(PDATA_W-POS_W){1'b0}}, last_position} : '0;

  // Command intake and queue.
  sspt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .head      (head),
    .pop       (pop)
  );

  // Execution and result stage.
  sspt_back u_back (
    .clk           (clk),
    .rst           (rst),
    .last_position (last_position),
    .head          (head),
    .pop           (pop),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .res_data      (res_data)
  );

  // A result always carries a one-hot coil pattern.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $onehot(res_data.coil_phase))
    else $error("coil pattern of a result is not one-hot");

  // After a command is accepted, the queue head is valid on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> head.valid)
    else $error("accepted command missing from queue");

  // A queued command stays queued until the back end takes it.
  assert property (@(posedge clk) disable iff (rst)
    (head.valid && !pop) |=> head.valid)
    else $error("queued command lost without being taken");

  // The back end never takes a command from an empty queue.
  assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from empty command queue");

endmodule
